// ----- hdl/key_debounce_click_detector_core_assert.svh -----
// ----------------------------------------------------------------------------
// key debounce click detector assertion macros
// shared property wrappers, clocked on aclk and muted during reset
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_CLICK_DETECTOR_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_CLICK_DETECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KDCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define KDCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define KDCD_ASSERT_NOW(label, ante, cons)
`define KDCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/kdcd_pkg.sv -----
// ----------------------------------------------------------------------------
// kdcd_pkg
// types, event codes, register indexes and reset values of the key debouncer
// ----------------------------------------------------------------------------
package kdcd_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int EVENT_W     = 3;
    localparam int CLICK_W     = 2;

    typedef logic [TIME_W-1:0]      time_t;
    typedef logic [CFG_W-1:0]       cfg_value_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [EVENT_W-1:0]     key_event_t;
    typedef logic [CLICK_W-1:0]     click_count_t;

    // event codes
    localparam key_event_t EVT_NONE    = 3'd0;
    localparam key_event_t EVT_PRESS   = 3'd1;
    localparam key_event_t EVT_RELEASE = 3'd2;
    localparam key_event_t EVT_LONG    = 3'd3;
    localparam key_event_t EVT_DOUBLE  = 3'd4;
    localparam key_event_t EVT_SHORT   = 3'd5;

    // register indexes
    localparam cfg_index_t REG_DEBOUNCE_TIME   = 2'd0;
    localparam cfg_index_t REG_LONG_PRESS_TIME = 2'd1;
    localparam cfg_index_t REG_DOUBLE_WINDOW   = 2'd2;

    // register reset values
    localparam cfg_value_t DEBOUNCE_TIME_RST   = 16'd15;
    localparam cfg_value_t LONG_PRESS_TIME_RST = 16'd600;
    localparam cfg_value_t DOUBLE_WINDOW_RST   = 16'd280;

    localparam click_count_t CLICK_MAX = 2'd3;
    localparam click_count_t CLICK_TWO = 2'd2;

endpackage

// ----- hdl/key_debounce_click_detector_core.sv -----
// ----------------------------------------------------------------------------
// key_debounce_click_detector_core
// single push-button debouncer with press, release, long-press and
// short/double-click events
// ----------------------------------------------------------------------------
// Each input word is one poll of the button: the raw pin level and the current
// millisecond timestamp. Every poll yields exactly one result word carrying a
// key event (none, press, release, long, double click, short click). A raw
// level becomes the debounced level once it has held for debounce_time ms;
// holding past long_press_time gives a single long event, and clicks pending
// for double_click_window ms after the last counted release are reported as a
// short or double click. All elapsed times use wrapping 32-bit subtraction.
// Throughput is one poll per clock while m_ready does not stall the output: the
// poll is captured in an input register, the event is worked out in one pass of
// compare and subtract logic against the button state, and lands in the result
// register. The state update in a single pass is what sets that rate. Stalls
// on m_ready back up through both registers; the input side keeps accepting
// while the result register is free or being drained.
// Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_wr_data; unknown indexes are ignored. The user must write them only
// while no poll is in flight; the block itself does not enforce this.

`include "key_debounce_click_detector_core_assert.svh"

module key_debounce_click_detector_core (
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration write port
    input  logic                    cfg_wr_en,
    input  kdcd_pkg::cfg_index_t    cfg_index,
    input  kdcd_pkg::cfg_value_t    cfg_wr_data,

    // poll input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_raw_level,
    input  kdcd_pkg::time_t         s_now_time,

    // event output
    output logic                    m_valid,
    input  logic                    m_ready,
    output kdcd_pkg::key_event_t    m_key_event
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    kdcd_pkg::cfg_value_t debounce_time_reg;
    kdcd_pkg::cfg_value_t long_press_time_reg;
    kdcd_pkg::cfg_value_t double_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg   <= kdcd_pkg::DEBOUNCE_TIME_RST;
            long_press_time_reg <= kdcd_pkg::LONG_PRESS_TIME_RST;
            double_window_reg   <= kdcd_pkg::DOUBLE_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                kdcd_pkg::REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_wr_data;
                kdcd_pkg::REG_LONG_PRESS_TIME: long_press_time_reg <= cfg_wr_data;
                kdcd_pkg::REG_DOUBLE_WINDOW:   double_window_reg   <= cfg_wr_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake
    // ------------------------------------------------------------------
    logic            in_valid_reg;
    logic            in_raw_reg;
    kdcd_pkg::time_t in_now_reg;

    logic                 m_valid_reg;
    kdcd_pkg::key_event_t m_key_event_reg;

    logic advance;   // input register word moves into the result register
    logic s_accept;

    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_raw_reg <= s_raw_level;
            in_now_reg <= s_now_time;
        end
    end

    // ------------------------------------------------------------------
    // button state
    // ------------------------------------------------------------------
    logic                   stable_level_reg, stable_level_next;
    logic                   last_sample_reg,  last_sample_next;
    kdcd_pkg::time_t        change_time_reg,  change_time_next;
    logic                   held_reg,         held_next;
    kdcd_pkg::click_count_t click_count_reg,  click_count_next;
    kdcd_pkg::time_t        release_time_reg, release_time_next;
    kdcd_pkg::key_event_t   result_event;

    kdcd_pkg::time_t elapsed;       // time since last raw edge
    kdcd_pkg::time_t since_release; // time since last counted click
    logic            sample_changed;
    logic            debounce_done;
    logic            long_reached;

    always_comb begin
        stable_level_next = stable_level_reg;
        held_next         = held_reg;
        click_count_next  = click_count_reg;
        release_time_next = release_time_reg;
        result_event      = kdcd_pkg::EVT_NONE;

        // a raw edge restarts the debounce timer, so elapsed is zero then
        sample_changed   = (in_raw_reg != last_sample_reg);
        last_sample_next = in_raw_reg;
        change_time_next = sample_changed ? in_now_reg : change_time_reg;
        elapsed          = sample_changed ? '0 : (in_now_reg - change_time_reg);

        debounce_done = (elapsed >= {16'd0, debounce_time_reg})
                        && (in_raw_reg != stable_level_reg);
        long_reached  = (elapsed >= {16'd0, long_press_time_reg});

        if (debounce_done) begin
            stable_level_next = in_raw_reg;
            if (in_raw_reg) begin
                held_next    = 1'b1;
                result_event = kdcd_pkg::EVT_PRESS;
            end else begin
                if (held_reg) begin
                    held_next = 1'b0;
                    if (!long_reached) begin
                        // short hold counts as a click, saturating
                        if (click_count_reg != kdcd_pkg::CLICK_MAX) begin
                            click_count_next = click_count_reg + 2'd1;
                        end
                        release_time_next = in_now_reg;
                    end else begin
                        result_event     = kdcd_pkg::EVT_LONG;
                        click_count_next = '0;
                    end
                end
                if (result_event == kdcd_pkg::EVT_NONE) begin
                    result_event = kdcd_pkg::EVT_RELEASE;
                end
            end
        end

        since_release = in_now_reg - release_time_next;

        // long hold wins over everything else of this poll
        priority if (held_next && long_reached) begin
            held_next        = 1'b0;
            click_count_next = '0;
            result_event     = kdcd_pkg::EVT_LONG;
        end else if ((click_count_next != '0)
                     && (since_release >= {16'd0, double_window_reg})) begin
            result_event = (click_count_next >= kdcd_pkg::CLICK_TWO)
                           ? kdcd_pkg::EVT_DOUBLE : kdcd_pkg::EVT_SHORT;
            click_count_next = '0;
        end else begin
            // nothing more this poll
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_level_reg <= 1'b0;
            last_sample_reg  <= 1'b0;
            change_time_reg  <= '0;
            held_reg         <= 1'b0;
            click_count_reg  <= '0;
            release_time_reg <= '0;
        end else if (advance) begin
            stable_level_reg <= stable_level_next;
            last_sample_reg  <= last_sample_next;
            change_time_reg  <= change_time_next;
            held_reg         <= held_next;
            click_count_reg  <= click_count_next;
            release_time_reg <= release_time_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_key_event_reg <= result_event;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_key_event = m_key_event_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic press_issued;  // a press word enters the result register
    assign press_issued = advance && (result_event == kdcd_pkg::EVT_PRESS);

    // held is only ever set together with a pressed debounced level
    `KDCD_ASSERT_NOW(a_held_implies_pressed, held_reg, stable_level_reg)
    // a reported press leaves the debounced level high
    `KDCD_ASSERT_NEXT(a_press_sets_level, press_issued, stable_level_reg)
    // input side only stalls when the result register is blocked
    `KDCD_ASSERT_NOW(a_stall_only_on_backpressure, !s_ready, in_valid_reg && m_valid_reg && !m_ready)

endmodule

// ----- tb/sv/key_debounce_click_detector_core_tb.sv -----
// ----------------------------------------------------------------------------
// key_debounce_click_detector_core_tb
// polls the debouncer with directed and random button traces and checks
// every key event word against a cycle-free model of the button state or a typed row's event
// ----------------------------------------------------------------------------
module key_debounce_click_detector_core_tb;

    // spare register index, writes to it must be ignored
    localparam kdcd_pkg::cfg_index_t REG_SPARE = 2'd3;

    // generous end of run, far beyond the slowest correct run
    localparam int unsigned RUN_LIMIT = 3_000_000;

    // long receiver hold-off, in cycles
    localparam int HOLD_OFF_CYCLES = 300;

    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_POLLS  = 230;
    localparam int DIRECTED_LEN = 28;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    kdcd_pkg::cfg_index_t   cfg_index;
    kdcd_pkg::cfg_value_t   cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_raw_level;
    kdcd_pkg::time_t        s_now_time;
    logic                   m_valid;
    logic                   m_ready;
    kdcd_pkg::key_event_t   m_key_event;

    key_debounce_click_detector_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_raw_level (s_raw_level),
        .s_now_time  (s_now_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_event (m_key_event)
    );

    // 10 unit clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // button model: debounce state, click tracking and configuration
    // ------------------------------------------------------------------
    kdcd_pkg::cfg_value_t   cfg_debounce;
    kdcd_pkg::cfg_value_t   cfg_long;
    kdcd_pkg::cfg_value_t   cfg_window;
    logic                   deb_level;
    logic                   prev_raw_level;
    kdcd_pkg::time_t        edge_time;
    logic                   key_held;
    kdcd_pkg::click_count_t clicks;
    kdcd_pkg::time_t        click_time;

    kdcd_pkg::key_event_t   expected_events[$];
    int                     mismatch_count;
    int                     event_count;

    // idle percentages for the two sides
    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;

    // hold-off request from the stimulus, served by the receiver process
    bit           hold_off_req;
    int           hold_off_left;

    // running millisecond cursor of the random traces
    kdcd_pkg::time_t trace_ms;

    task automatic reset_key_model();
        cfg_debounce   = kdcd_pkg::DEBOUNCE_TIME_RST;
        cfg_long       = kdcd_pkg::LONG_PRESS_TIME_RST;
        cfg_window     = kdcd_pkg::DOUBLE_WINDOW_RST;
        deb_level      = 1'b0;
        prev_raw_level = 1'b0;
        edge_time      = '0;
        key_held       = 1'b0;
        clicks         = '0;
        click_time     = '0;
    endtask

    // advances the model by one poll and returns the event it reports
    function automatic kdcd_pkg::key_event_t predict_key_event(logic raw,
                                                               kdcd_pkg::time_t now);
        kdcd_pkg::key_event_t ev;
        kdcd_pkg::time_t      elapsed;
        kdcd_pkg::time_t      since_click;
        ev = kdcd_pkg::EVT_NONE;
        // any raw edge restarts the hold timer
        if (raw != prev_raw_level) begin
            prev_raw_level = raw;
            edge_time      = now;
        end
        elapsed = now - edge_time;
        if (elapsed >= kdcd_pkg::time_t'(cfg_debounce) && raw != deb_level) begin
            deb_level = raw;
            if (deb_level) begin
                key_held = 1'b1;
                ev       = kdcd_pkg::EVT_PRESS;
            end else begin
                if (key_held) begin
                    key_held = 1'b0;
                    // release measured from the raw release edge
                    if (elapsed < kdcd_pkg::time_t'(cfg_long)) begin
                        if (clicks != kdcd_pkg::CLICK_MAX) begin
                            clicks = clicks + 2'd1;
                        end
                        click_time = now;
                    end else begin
                        ev     = kdcd_pkg::EVT_LONG;
                        clicks = '0;
                    end
                end
                if (ev == kdcd_pkg::EVT_NONE) begin
                    ev = kdcd_pkg::EVT_RELEASE;
                end
            end
        end
        // held past the long time wins over everything in this poll
        if (key_held && elapsed >= kdcd_pkg::time_t'(cfg_long)) begin
            key_held = 1'b0;
            clicks   = '0;
            return kdcd_pkg::EVT_LONG;
        end
        // click window check runs last and overrides press or release
        since_click = now - click_time;
        if (clicks != '0 && since_click >= kdcd_pkg::time_t'(cfg_window)) begin
            ev     = (clicks >= kdcd_pkg::CLICK_TWO) ? kdcd_pkg::EVT_DOUBLE
                                                     : kdcd_pkg::EVT_SHORT;
            clicks = '0;
        end
        return ev;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // directed trace, reset configuration (15 / 600 / 280)
    // typed flag set where the event is known outright
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                 raw;
        kdcd_pkg::time_t      now;
        logic                 typed;
        kdcd_pkg::key_event_t want;
    } poll_row_t;

    poll_row_t directed_polls [DIRECTED_LEN] = '{
        // level right after reset, nothing to report
        '{1'b0, 32'd0,          1'b1, kdcd_pkg::EVT_NONE},
        // single click: press one short of debounce, then confirmed
        '{1'b1, 32'd100,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd114,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd115,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd200,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd215,        1'b0, kdcd_pkg::EVT_NONE},
        // window edge, one short of it and then on it
        '{1'b0, 32'd494,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd495,        1'b0, kdcd_pkg::EVT_NONE},
        // double click
        '{1'b1, 32'd1000,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd1015,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd1050,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd1065,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd1100,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd1115,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd1150,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd1165,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd1445,       1'b0, kdcd_pkg::EVT_NONE},
        // long press while held, then a plain release
        '{1'b1, 32'd2000,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd2015,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd2599,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd2600,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'd3000,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd3100,       1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd3115,       1'b0, kdcd_pkg::EVT_NONE},
        // press across the timestamp wrap
        '{1'b1, 32'hFFFF_FFF8,  1'b0, kdcd_pkg::EVT_NONE},
        '{1'b1, 32'h0000_0007,  1'b1, kdcd_pkg::EVT_PRESS},
        // release edge, then a late poll past the long time
        '{1'b0, 32'd100,        1'b0, kdcd_pkg::EVT_NONE},
        '{1'b0, 32'd900,        1'b1, kdcd_pkg::EVT_LONG}
    };

    // ------------------------------------------------------------------
    // input side: one poll word, random gap first, held until accepted
    // ------------------------------------------------------------------
    task automatic send_poll(logic raw, kdcd_pkg::time_t now, logic typed,
                             kdcd_pkg::key_event_t want);
        int                   gap;
        kdcd_pkg::key_event_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            gap++;
        end
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_raw_level <= raw;
        s_now_time  <= now;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        // word accepted: advance the model
        predicted = predict_key_event(raw, now);
        expected_events.push_back(typed ? want : predicted);
    endtask

    // sender pause until every expected event has come back
    task automatic drain_events();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_events.size() != 0) begin
            @(posedge aclk);
        end
        // pipeline depth is two words, leave some margin
        repeat (4) @(posedge aclk);
    endtask

    // register write, only called while nothing is in flight
    task automatic write_reg(kdcd_pkg::cfg_index_t idx, kdcd_pkg::cfg_value_t value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            kdcd_pkg::REG_DEBOUNCE_TIME:   cfg_debounce = value;
            kdcd_pkg::REG_LONG_PRESS_TIME: cfg_long     = value;
            kdcd_pkg::REG_DOUBLE_WINDOW:   cfg_window   = value;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // random button trace: mostly press / release with bounces, some noise
    // ------------------------------------------------------------------
    task automatic run_button_trace(int polls, int unsigned span, bit with_hold_off);
        logic            level;
        logic            raw;
        int              hold_left;
        kdcd_pkg::time_t step_ms;
        level     = 1'b0;
        hold_left = 0;
        for (int i = 0; i < polls; i++) begin
            if (with_hold_off && i == polls / 2) begin
                hold_off_req = 1'b1;
            end
            if (hold_left == 0) begin
                level     = ~level;
                hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24)
                                                        : $urandom_range(1, 6);
            end
            hold_left--;
            if ($urandom_range(0, 99) < 8) begin
                // noise: any level, any timestamp, cursor jumps with it
                raw      = 1'($urandom_range(0, 1));
                trace_ms = $urandom();
            end else begin
                // short steps make bounces inside the debounce time
                if ($urandom_range(0, 99) < 30) begin
                    step_ms = $urandom_range(0, 3);
                end else begin
                    step_ms = $urandom_range(0, span);
                end
                trace_ms = trace_ms + step_ms;
                raw      = ($urandom_range(0, 99) < 10) ? ~level : level;
            end
            send_poll(raw, trace_ms, 1'b0, kdcd_pkg::EVT_NONE);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random ready, long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // event checker, oldest expectation first
    always @(posedge aclk) begin : check_events
        kdcd_pkg::key_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event word %0d: key_event %0d with none expected",
                                          event_count, m_key_event));
            end else begin
                want = expected_events.pop_front();
                if (m_key_event !== want) begin
                    report_mismatch($sformatf("event word %0d: key_event %0d, want %0d",
                                              event_count, m_key_event, want));
                end
            end
            event_count++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        kdcd_pkg::cfg_value_t  deb_set  [PHASE_COUNT];
        kdcd_pkg::cfg_value_t  long_set [PHASE_COUNT];
        kdcd_pkg::cfg_value_t  win_set  [PHASE_COUNT];
        kdcd_pkg::cfg_value_t  widest;
        int unsigned           span;

        // known levels from time zero
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = kdcd_pkg::REG_DEBOUNCE_TIME;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_raw_level    = 1'b0;
        s_now_time     = '0;
        m_ready        = 1'b0;
        hold_off_req   = 1'b0;
        hold_off_left  = 0;
        mismatch_count = 0;
        event_count    = 0;
        trace_ms       = '0;
        tx_idle_pct    = 21;
        rx_idle_pct    = 81;
        reset_key_model();

        // settings per phase: defaults, all zero, all max, small,
        // debounce above long with zero window, random
        deb_set  = '{16'd15,  16'd0, 16'hFFFF, 16'd3,  16'd20, 16'd0};
        long_set = '{16'd600, 16'd0, 16'hFFFF, 16'd40, 16'd10, 16'd0};
        win_set  = '{16'd280, 16'd0, 16'hFFFF, 16'd20, 16'd0,  16'd0};
        deb_set[5]  = kdcd_pkg::cfg_value_t'($urandom_range(0, 50));
        long_set[5] = kdcd_pkg::cfg_value_t'($urandom_range(0, 400));
        win_set[5]  = kdcd_pkg::cfg_value_t'($urandom_range(0, 200));

        // single reset at the start
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part on reset register values
        for (int r = 0; r < DIRECTED_LEN; r++) begin
            send_poll(directed_polls[r].raw, directed_polls[r].now,
                      directed_polls[r].typed, directed_polls[r].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_events();
            write_reg(kdcd_pkg::REG_DEBOUNCE_TIME,   deb_set[p]);
            write_reg(kdcd_pkg::REG_LONG_PRESS_TIME, long_set[p]);
            write_reg(kdcd_pkg::REG_DOUBLE_WINDOW,   win_set[p]);
            if (p == 3) begin
                // spare index, must leave every register alone
                write_reg(REG_SPARE, kdcd_pkg::cfg_value_t'($urandom()));
            end
            // rotate idling: slow receiver, slow sender, none
            case (p % 3)
                0: begin tx_idle_pct = 21; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 21; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // time steps scaled to the slowest threshold
            widest = deb_set[p];
            if (long_set[p] > widest) widest = long_set[p];
            if (win_set[p] > widest)  widest = win_set[p];
            span = 32'(widest) / 4 + 2;
            // start some phases just short of the timestamp wrap
            if (p % 2 == 1) begin
                trace_ms = 32'hFFFF_FFFF - kdcd_pkg::time_t'($urandom_range(0, 4 * span));
            end
            run_button_trace(PHASE_POLLS, span, (p == 0 || p == 3 || p == 5));
        end

        drain_events();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("key_debounce_click_detector_core_tb passed");
        end else begin
            $display("key_debounce_click_detector_core_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("key_debounce_click_detector_core_tb failed");
        $finish;
    end

endmodule
